FILE: sv/tcs_pkg.sv
`default_nettype none

package tcs_pkg;

  // internal exponent width, value of sig msb is 2^(exp - 1023)
  localparam int EXP_W = 14;

  // result queue between evaluation and delivery
  localparam int QDEPTH = 32;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0000;

  // element type codes, anything above TY_BOOL compares raw bits
  localparam logic [3:0] TY_F32  = 4'd0;
  localparam logic [3:0] TY_F64  = 4'd1;
  localparam logic [3:0] TY_F16  = 4'd2;
  localparam logic [3:0] TY_BF16 = 4'd3;
  localparam logic [3:0] TY_I8   = 4'd4;
  localparam logic [3:0] TY_I16  = 4'd5;
  localparam logic [3:0] TY_I32  = 4'd6;
  localparam logic [3:0] TY_I64  = 4'd7;
  localparam logic [3:0] TY_U8   = 4'd8;
  localparam logic [3:0] TY_U16  = 4'd9;
  localparam logic [3:0] TY_U32  = 4'd10;
  localparam logic [3:0] TY_U64  = 4'd11;
  localparam logic [3:0] TY_BOOL = 4'd12;
  localparam logic [3:0] TY_RAW  = 4'd13;

  // configuration register indexes
  localparam logic [1:0] CFG_ELEM_TYPE = 2'd0;
  localparam logic [1:0] CFG_RTOL      = 2'd1;
  localparam logic [1:0] CFG_ATOL      = 2'd2;
  localparam logic [1:0] CFG_NAN_EQ    = 2'd3;

  typedef enum logic [2:0] {
    ST_MATCH = 3'd0,
    ST_NAN   = 3'd1,
    ST_INF   = 3'd2,
    ST_TOL   = 3'd3,
    ST_RAW   = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] actual_value;
    logic [63:0] expected_value;
    logic        last_element;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] element_index;
    logic [31:0] first_failure_index;
    logic        any_failure;
    logic        tensor_done;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]  element_type;
    logic [63:0] rtol;
    logic [63:0] atol;
    logic        nan_equal;
  } cfg_regs_t;

  // special flags and exponent that go with an unrounded significand
  typedef struct packed {
    logic                    nan;
    logic                    inf;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
  } rnd_flags_t;

  typedef struct packed {
    status_t status;
    logic    last;
  } eval_res_t;

endpackage

`default_nettype wire

FILE: sv/tcs_round.sv
`default_nettype none

module tcs_round
  import tcs_pkg::*;
#(
  parameter int W = 64
) (
  input  wire logic             clk,
  input  wire rnd_flags_t       flags_in,
  input  wire logic [W-1:0]     sig_in,
  output logic      [63:0]      dbl_out
);

  localparam int G = W / 8;
  localparam int LZW = $clog2(W + 1);
  localparam int VW = EXP_W + 52;

  function automatic logic [2:0] lzc8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  // stage 1: per-byte leading zero counts
  rnd_flags_t s1_flags;
  logic [W-1:0] s1_sig;
  logic [G-1:0] s1_nz;
  logic [2:0] s1_lz [G];

  always_ff @(posedge clk) begin
    s1_flags <= flags_in;
    s1_sig <= sig_in;
    for (int g = 0; g < G; g++) begin
      s1_nz[g] <= |sig_in[W-1-8*g -: 8];
      s1_lz[g] <= lzc8(sig_in[W-1-8*g -: 8]);
    end
  end

  // stage 2: pick first nonzero byte and normalize
  logic [LZW-1:0] lz_total;
  logic lz_zero;
  logic signed [EXP_W-1:0] s1_exp;

  always_comb begin
    lz_total = '0;
    lz_zero = 1'b1;
    for (int g = G - 1; g >= 0; g--) begin
      if (s1_nz[g]) begin
        lz_total = LZW'(8 * g) + LZW'(s1_lz[g]);
        lz_zero = 1'b0;
      end
    end
  end

  assign s1_exp = s1_flags.exp;

  rnd_flags_t s2_flags;
  logic s2_zero;
  logic [W-1:0] s2_sig;

  always_ff @(posedge clk) begin
    s2_flags.nan <= s1_flags.nan;
    s2_flags.inf <= s1_flags.inf;
    s2_flags.sign <= s1_flags.sign;
    s2_flags.exp <= s1_exp - $signed(EXP_W'(lz_total));
    s2_zero <= lz_zero;
    s2_sig <= s1_sig << lz_total;
  end

  // stage 3: shift right into the subnormal range with sticky jam
  logic signed [EXP_W-1:0] s2_exp;
  logic signed [EXP_W-1:0] rs;
  logic [W-1:0] dn_sig;
  logic signed [EXP_W-1:0] dn_exp;
  logic lost;

  assign s2_exp = s2_flags.exp;
  assign rs = EXP_W'(1) - s2_exp;

  always_comb begin
    dn_sig = s2_sig;
    dn_exp = s2_exp;
    lost = 1'b0;
    if (s2_exp < EXP_W'(1)) begin
      dn_exp = EXP_W'(1);
      if (rs >= EXP_W'(W)) begin
        dn_sig = '0;
        lost = |s2_sig;
      end else begin
        dn_sig = s2_sig >> rs;
        lost = |(s2_sig << (EXP_W'(W) - rs));
      end
      dn_sig[0] = dn_sig[0] | lost;
    end
  end

  rnd_flags_t s3_flags;
  logic s3_zero;
  logic [W-1:0] s3_sig;

  always_ff @(posedge clk) begin
    s3_flags.nan <= s2_flags.nan;
    s3_flags.inf <= s2_flags.inf;
    s3_flags.sign <= s2_flags.sign;
    s3_flags.exp <= dn_exp;
    s3_zero <= s2_zero;
    s3_sig <= dn_sig;
  end

  // stage 4: round to nearest even and pack
  logic [52:0] m53;
  logic guard;
  logic sticky;
  logic inc;
  logic [VW-1:0] packed_val;
  logic ovf;
  logic signed [EXP_W-1:0] s3_exp;

  assign s3_exp = s3_flags.exp;
  assign m53 = s3_sig[W-1 -: 53];
  assign guard = s3_sig[W-54];
  assign sticky = |s3_sig[W-55:0];
  assign inc = guard & (sticky | m53[0]);
  assign packed_val = (VW'(s3_exp - EXP_W'(1)) << 52) + VW'(m53) + VW'(inc);
  assign ovf = packed_val >= (VW'(2047) << 52);

  always_ff @(posedge clk) begin
    priority if (s3_flags.nan) begin
      dbl_out <= QNAN;
    end else if (s3_flags.inf || (ovf && !s3_zero)) begin
      dbl_out <= {s3_flags.sign, 11'h7FF, 52'd0};
    end else if (s3_zero) begin
      dbl_out <= {s3_flags.sign, 63'd0};
    end else begin
      dbl_out <= {s3_flags.sign, packed_val[62:0]};
    end
  end

endmodule

`default_nettype wire

FILE: sv/tcs_add.sv
`default_nettype none

module tcs_add
  import tcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  output logic      [63:0] sum
);

  // stage 1: classify and order by magnitude
  logic [10:0] xe, ye, xe_eff, ye_eff;
  logic x_nan, y_nan, x_inf, y_inf, x_big;

  assign xe = x[62:52];
  assign ye = y[62:52];
  assign xe_eff = (xe == 11'd0) ? 11'd1 : xe;
  assign ye_eff = (ye == 11'd0) ? 11'd1 : ye;
  assign x_nan = (&xe) && (|x[51:0]);
  assign y_nan = (&ye) && (|y[51:0]);
  assign x_inf = (&xe) && !(|x[51:0]);
  assign y_inf = (&ye) && !(|y[51:0]);
  assign x_big = x[62:0] >= y[62:0];

  logic a1_nan, a1_inf, a1_inf_sign, a1_sign, a1_sub;
  logic [10:0] a1_exp, a1_d;
  logic [52:0] a1_bm, a1_sm;

  always_ff @(posedge clk) begin
    a1_nan <= x_nan || y_nan || (x_inf && y_inf && (x[63] != y[63]));
    a1_inf <= x_inf || y_inf;
    a1_inf_sign <= x_inf ? x[63] : y[63];
    a1_sub <= x[63] != y[63];
    if (x_big) begin
      a1_sign <= x[63];
      a1_exp <= xe_eff;
      a1_d <= xe_eff - ye_eff;
      a1_bm <= {xe != 11'd0, x[51:0]};
      a1_sm <= {ye != 11'd0, y[51:0]};
    end else begin
      a1_sign <= y[63];
      a1_exp <= ye_eff;
      a1_d <= ye_eff - xe_eff;
      a1_bm <= {ye != 11'd0, y[51:0]};
      a1_sm <= {xe != 11'd0, x[51:0]};
    end
  end

  // stage 2: align the smaller operand, jam shifted-out bits
  logic [63:0] b0, b_al;

  assign b0 = {1'b0, a1_sm, 10'd0};

  always_comb begin
    if (a1_d >= 11'd64) begin
      b_al = {63'd0, |a1_sm};
    end else if (a1_d == 11'd0) begin
      b_al = b0;
    end else begin
      b_al = b0 >> a1_d;
      b_al[0] = b_al[0] | (|(b0 << (11'd64 - a1_d)));
    end
  end

  logic a2_nan, a2_inf, a2_inf_sign, a2_sign, a2_sub;
  logic [10:0] a2_exp;
  logic [63:0] a2_a, a2_b;

  always_ff @(posedge clk) begin
    a2_nan <= a1_nan;
    a2_inf <= a1_inf;
    a2_inf_sign <= a1_inf_sign;
    a2_sign <= a1_sign;
    a2_sub <= a1_sub;
    a2_exp <= a1_exp;
    a2_a <= {1'b0, a1_bm, 10'd0};
    a2_b <= b_al;
  end

  // stage 3: add or subtract magnitudes
  rnd_flags_t a3_flags;
  logic [63:0] a3_sig;

  always_ff @(posedge clk) begin
    a3_flags.nan <= a2_nan;
    a3_flags.inf <= a2_inf;
    a3_flags.sign <= a2_inf ? a2_inf_sign : a2_sign;
    a3_flags.exp <= $signed(EXP_W'(a2_exp)) + EXP_W'(1);
    a3_sig <= a2_sub ? (a2_a - a2_b) : (a2_a + a2_b);
  end

  tcs_round #(.W(64)) u_round (
    .clk      (clk),
    .flags_in (a3_flags),
    .sig_in   (a3_sig),
    .dbl_out  (sum)
  );

endmodule

`default_nettype wire

FILE: sv/tcs_mul.sv
`default_nettype none

module tcs_mul
  import tcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  output logic      [63:0] prod
);

  logic [10:0] xe, ye, xe_eff, ye_eff;
  logic [52:0] mx, my;
  logic x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;

  assign xe = x[62:52];
  assign ye = y[62:52];
  assign xe_eff = (xe == 11'd0) ? 11'd1 : xe;
  assign ye_eff = (ye == 11'd0) ? 11'd1 : ye;
  assign mx = {xe != 11'd0, x[51:0]};
  assign my = {ye != 11'd0, y[51:0]};
  assign x_nan = (&xe) && (|x[51:0]);
  assign y_nan = (&ye) && (|y[51:0]);
  assign x_inf = (&xe) && !(|x[51:0]);
  assign y_inf = (&ye) && !(|y[51:0]);
  assign x_zero = x[62:0] == 63'd0;
  assign y_zero = y[62:0] == 63'd0;

  // stage 1: four partial products of 27/26 bit halves
  rnd_flags_t m1_flags;
  logic [53:0] pp_hh;
  logic [52:0] pp_hl, pp_lh;
  logic [51:0] pp_ll;

  always_ff @(posedge clk) begin
    m1_flags.nan <= x_nan || y_nan || (x_inf && y_zero) || (x_zero && y_inf);
    m1_flags.inf <= x_inf || y_inf;
    m1_flags.sign <= x[63] ^ y[63];
    m1_flags.exp <= $signed(EXP_W'(xe_eff)) + $signed(EXP_W'(ye_eff)) - EXP_W'(1022);
    pp_hh <= mx[52:26] * my[52:26];
    pp_hl <= mx[52:26] * my[25:0];
    pp_lh <= mx[25:0] * my[52:26];
    pp_ll <= mx[25:0] * my[25:0];
  end

  // stage 2: sum partial products into the full product
  rnd_flags_t m2_flags;
  logic [111:0] m2_sig;
  logic [105:0] full;

  assign full = (106'(pp_hh) << 52) + ((106'(pp_hl) + 106'(pp_lh)) << 26) + 106'(pp_ll);

  always_ff @(posedge clk) begin
    m2_flags <= m1_flags;
    m2_sig <= {full, 6'd0};
  end

  tcs_round #(.W(112)) u_round (
    .clk      (clk),
    .flags_in (m2_flags),
    .sig_in   (m2_sig),
    .dbl_out  (prod)
  );

endmodule

`default_nettype wire

FILE: sv/tcs_eval.sv
`default_nettype none

module tcs_eval
  import tcs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      beat_in,
  input  wire in_beat_t  in_data,
  input  wire cfg_regs_t cfg,
  output logic           res_valid,
  output eval_res_t      res
);

  // stage alignment: decode, then multiply, then bound add, then compare
  localparam int SIDE_DLY = 18;
  localparam int CLS_DLY = 13;
  localparam int DIFF_DLY = 6;

  typedef struct packed {
    rnd_flags_t  f;
    logic [63:0] sig;
  } dec_t;

  typedef struct packed {
    logic last;
    logic raw;
    logic raw_neq;
  } side_t;

  typedef struct packed {
    status_t status;
    logic    use_cmp;
  } cls_t;

  // element bits to sign, exponent and unrounded significand
  function automatic dec_t fmt(input logic [3:0] t, input logic [63:0] x);
    dec_t d;
    logic [63:0] sext;
    logic neg;
    logic [7:0] e8;
    logic [4:0] e5;
    logic [10:0] e11;
    d = '0;
    sext = '0;
    neg = 1'b0;
    e8 = '0;
    e5 = '0;
    e11 = '0;
    d.f.exp = EXP_W'(1086);
    unique case (t)
      TY_F32: begin
        e8 = x[30:23];
        d.f.sign = x[31];
        d.f.nan = (&e8) && (|x[22:0]);
        d.f.inf = (&e8) && !(|x[22:0]);
        d.sig = {e8 != 8'd0, x[22:0], 40'd0};
        d.f.exp = $signed(EXP_W'((e8 == 8'd0) ? 8'd1 : e8)) + EXP_W'(896);
      end
      TY_F64: begin
        e11 = x[62:52];
        d.f.sign = x[63];
        d.f.nan = (&e11) && (|x[51:0]);
        d.f.inf = (&e11) && !(|x[51:0]);
        d.sig = {e11 != 11'd0, x[51:0], 11'd0};
        d.f.exp = $signed(EXP_W'((e11 == 11'd0) ? 11'd1 : e11));
      end
      TY_F16: begin
        e5 = x[14:10];
        d.f.sign = x[15];
        d.f.nan = (&e5) && (|x[9:0]);
        d.f.inf = (&e5) && !(|x[9:0]);
        d.sig = {e5 != 5'd0, x[9:0], 53'd0};
        d.f.exp = $signed(EXP_W'((e5 == 5'd0) ? 5'd1 : e5)) + EXP_W'(1008);
      end
      TY_BF16: begin
        e8 = x[14:7];
        d.f.sign = x[15];
        d.f.nan = (&e8) && (|x[6:0]);
        d.f.inf = (&e8) && !(|x[6:0]);
        d.sig = {e8 != 8'd0, x[6:0], 56'd0};
        d.f.exp = $signed(EXP_W'((e8 == 8'd0) ? 8'd1 : e8)) + EXP_W'(896);
      end
      TY_I8: begin
        neg = x[7];
        sext = {{56{x[7]}}, x[7:0]};
      end
      TY_I16: begin
        neg = x[15];
        sext = {{48{x[15]}}, x[15:0]};
      end
      TY_I32: begin
        neg = x[31];
        sext = {{32{x[31]}}, x[31:0]};
      end
      TY_I64: begin
        neg = x[63];
        sext = x;
      end
      TY_U8:   sext = {56'd0, x[7:0]};
      TY_U16:  sext = {48'd0, x[15:0]};
      TY_U32:  sext = {32'd0, x[31:0]};
      TY_U64:  sext = x;
      TY_BOOL: sext = {56'd0, x[7:0]};
      default: sext = '0;
    endcase
    // integer types: magnitude with msb weight 2^63
    if (t >= TY_I8) begin
      d.f.sign = neg;
      d.sig = neg ? (~sext + 64'd1) : sext;
    end
    return d;
  endfunction

  // front stage: register beat and classify
  dec_t e1_a, e1_b;
  logic [SIDE_DLY-1:0] side_v;
  side_t side_p [SIDE_DLY];

  always_ff @(posedge clk) begin
    e1_a <= fmt(cfg.element_type, in_data.actual_value);
    e1_b <= fmt(cfg.element_type, in_data.expected_value);
    side_p[0].last <= in_data.last_element;
    side_p[0].raw <= cfg.element_type >= TY_RAW;
    side_p[0].raw_neq <= in_data.actual_value != in_data.expected_value;
    for (int i = 1; i < SIDE_DLY; i++) begin
      side_p[i] <= side_p[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_v <= '0;
    end else begin
      side_v <= {side_v[SIDE_DLY-2:0], beat_in};
    end
  end

  // decode both operands to double
  logic [63:0] a_dbl, b_dbl;

  tcs_round #(.W(64)) u_dec_a (
    .clk      (clk),
    .flags_in (e1_a.f),
    .sig_in   (e1_a.sig),
    .dbl_out  (a_dbl)
  );

  tcs_round #(.W(64)) u_dec_b (
    .clk      (clk),
    .flags_in (e1_b.f),
    .sig_in   (e1_b.sig),
    .dbl_out  (b_dbl)
  );

  // nan and infinity outcomes, carried alongside the arithmetic
  logic na, nb, ia, ib;
  cls_t cls_now;
  cls_t cls_dl [CLS_DLY];

  assign na = (&a_dbl[62:52]) && (|a_dbl[51:0]);
  assign nb = (&b_dbl[62:52]) && (|b_dbl[51:0]);
  assign ia = (&a_dbl[62:52]) && !(|a_dbl[51:0]);
  assign ib = (&b_dbl[62:52]) && !(|b_dbl[51:0]);

  always_comb begin
    cls_now.use_cmp = 1'b0;
    priority if (na || nb) begin
      cls_now.status = (cfg.nan_equal && na && nb) ? ST_MATCH : ST_NAN;
    end else if (ia || ib) begin
      cls_now.status = (a_dbl == b_dbl) ? ST_MATCH : ST_INF;
    end else begin
      cls_now.status = ST_MATCH;
      cls_now.use_cmp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cls_dl[0] <= cls_now;
    for (int i = 1; i < CLS_DLY; i++) begin
      cls_dl[i] <= cls_dl[i-1];
    end
  end

  // a - b and rtol * |b| in parallel, then atol + scaled bound
  logic [63:0] diff, scaled, bound;
  logic [63:0] diff_dl [DIFF_DLY];

  tcs_add u_sub (
    .clk (clk),
    .x   (a_dbl),
    .y   ({~b_dbl[63], b_dbl[62:0]}),
    .sum (diff)
  );

  tcs_mul u_mul (
    .clk  (clk),
    .x    (cfg.rtol),
    .y    ({1'b0, b_dbl[62:0]}),
    .prod (scaled)
  );

  tcs_add u_bound (
    .clk (clk),
    .x   (cfg.atol),
    .y   (scaled),
    .sum (bound)
  );

  always_ff @(posedge clk) begin
    diff_dl[0] <= diff;
    for (int i = 1; i < DIFF_DLY; i++) begin
      diff_dl[i] <= diff_dl[i-1];
    end
  end

  // |diff| > bound, false when the bound is nan
  logic [62:0] dmag;
  logic bound_nan, over;
  side_t sd;
  cls_t cl;

  assign dmag = diff_dl[DIFF_DLY-1][62:0];
  assign bound_nan = (&bound[62:52]) && (|bound[51:0]);
  assign sd = side_p[SIDE_DLY-1];
  assign cl = cls_dl[CLS_DLY-1];

  always_comb begin
    priority if (bound_nan) begin
      over = 1'b0;
    end else if (bound[63]) begin
      over = !((dmag == 63'd0) && (bound[62:0] == 63'd0));
    end else begin
      over = dmag > bound[62:0];
    end
  end

  always_ff @(posedge clk) begin
    res.last <= sd.last;
    priority if (sd.raw) begin
      res.status <= sd.raw_neq ? ST_RAW : ST_MATCH;
    end else if (cl.use_cmp) begin
      res.status <= over ? ST_TOL : ST_MATCH;
    end else begin
      res.status <= cl.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= side_v[SIDE_DLY-1];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tcs_back.sv
`default_nettype none

module tcs_back
  import tcs_pkg::*;
#(
  parameter int INDEX_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      beat_in,
  input  wire logic      res_valid,
  input  wire eval_res_t res,
  output logic           credit_ok,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  // result queue with wrap bit on the pointers
  eval_res_t q [QDEPTH];
  logic [QAW:0] wr_ptr, rd_ptr;
  logic [QAW:0] occ;
  logic q_empty, q_full, pop;
  eval_res_t head;

  assign q_empty = wr_ptr == rd_ptr;
  assign q_full = (wr_ptr[QAW] != rd_ptr[QAW]) && (wr_ptr[QAW-1:0] == rd_ptr[QAW-1:0]);
  assign pop = !q_empty && (!out_valid || out_ready);
  assign head = q[rd_ptr[QAW-1:0]];

  // beats accepted and not yet moved to the output register
  assign credit_ok = occ < (QAW + 1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wr_ptr[QAW-1:0]] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ <= '0;
    end else begin
      if (res_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      occ <= occ + (QAW + 1)'(beat_in) - (QAW + 1)'(pop);
    end
  end

  // running tensor state
  logic [INDEX_BITS-1:0] counter, first_bad;
  logic seen;
  logic fail, seen_next;
  logic [INDEX_BITS-1:0] first_next;

  assign fail = head.status != ST_MATCH;
  assign seen_next = seen || fail;
  assign first_next = (!seen && fail) ? counter : first_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      first_bad <= '0;
      seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          counter <= '0;
          first_bad <= '0;
          seen <= 1'b0;
        end else begin
          counter <= counter + 1'b1;
          first_bad <= first_next;
          seen <= seen_next;
        end
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.status <= head.status;
      out_data.element_index <= 32'(counter);
      out_data.first_failure_index <= 32'(first_next);
      out_data.any_failure <= seen_next;
      out_data.tensor_done <= head.last;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= (QAW + 1)'(QDEPTH))
    else $error("credit count above queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !q_full)
    else $error("result written into full queue");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (counter == '0) && !seen)
    else $error("tensor state not cleared after last beat");
`endif

endmodule

`default_nettype wire

FILE: sv/tolerance_compare_stream.sv
// throughput: one beat per cycle, limited by 32 credits on the result queue
// arithmetic: decode, then subtract and multiply in parallel, then bound add, then compare
// reset: synchronous rst clears configuration, counters, queue and valids
`default_nettype none

module tolerance_compare_stream
  import tcs_pkg::*;
#(
  parameter int INDEX_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_regs_t cfg;
  logic beat_in;
  logic res_valid;
  eval_res_t res;

  assign beat_in = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ELEM_TYPE: cfg.element_type <= cfg_data[3:0];
        CFG_RTOL:      cfg.rtol <= cfg_data;
        CFG_ATOL:      cfg.atol <= cfg_data;
        CFG_NAN_EQ:    cfg.nan_equal <= cfg_data[0];
      endcase
    end
  end

  tcs_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .beat_in   (beat_in),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  tcs_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .beat_in   (beat_in),
    .res_valid (res_valid),
    .res       (res),
    .credit_ok (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_tolerance_compare_stream.sv
`timescale 1ns / 100ps

module tb_tolerance_compare_stream;
  import tcs_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  tolerance_compare_stream dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block's registers and running tensor state
  logic [3:0]  sh_type;
  logic [63:0] sh_rtol;
  logic [63:0] sh_atol;
  logic        sh_nan_eq;
  logic [31:0] run_index;
  logic        run_failed;
  logic [31:0] run_first_bad;

  out_beat_t   verdict_q[$];
  int          mismatch_count;
  int          burst_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // double helpers, special values judged by bit pattern
  function automatic logic dbl_is_nan(real v);
    logic [63:0] b;
    b = $realtobits(v);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic dbl_is_inf(real v);
    logic [63:0] b;
    b = $realtobits(v);
    return (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
  endfunction

  function automatic real u64_to_real(logic [63:0] x);
    // one rounding only: the high part scaled is exact
    return real'(x[63:32]) * 4294967296.0 + real'(x[31:0]);
  endfunction

  function automatic real sint_to_real(logic [63:0] x, int width);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    v = x & mask;
    if (v[width-1]) begin
      return -u64_to_real(((~v) & mask) + 64'd1);
    end
    return u64_to_real(v);
  endfunction

  function automatic real single_to_real(logic [31:0] b);
    logic [7:0] ex;
    ex = b[30:23];
    if (ex == 8'd0) begin
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) / (2.0 ** 149);
    end
    if (ex == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    end
    return $bitstoreal({b[31], 11'(ex + 11'd896), b[22:0], 29'd0});
  endfunction

  function automatic real half_to_real(logic [15:0] h);
    logic [4:0] ex;
    ex = h[14:10];
    if (ex == 5'd0) begin
      return (h[15] ? -1.0 : 1.0) * real'(h[9:0]) / (2.0 ** 24);
    end
    if (ex == 5'h1F) begin
      return $bitstoreal({h[15], 11'h7FF, h[9:0], 42'd0});
    end
    return $bitstoreal({h[15], 11'(ex + 11'd1008), h[9:0], 42'd0});
  endfunction

  function automatic real element_to_real(logic [3:0] t, logic [63:0] x);
    case (t)
      TY_F32:  return single_to_real(x[31:0]);
      TY_F64:  return $bitstoreal(x);
      TY_F16:  return half_to_real(x[15:0]);
      TY_BF16: return single_to_real({x[15:0], 16'd0});
      TY_I8:   return sint_to_real(x, 8);
      TY_I16:  return sint_to_real(x, 16);
      TY_I32:  return sint_to_real(x, 32);
      TY_I64:  return sint_to_real(x, 64);
      TY_U8:   return u64_to_real({56'd0, x[7:0]});
      TY_U16:  return u64_to_real({48'd0, x[15:0]});
      TY_U32:  return u64_to_real({32'd0, x[31:0]});
      TY_U64:  return u64_to_real(x);
      default: return u64_to_real({56'd0, x[7:0]});
    endcase
  endfunction

  // allclose status of one pair under the shadow configuration
  function automatic status_t pair_status(logic [63:0] av, logic [63:0] ev);
    real a;
    real b;
    real diff;
    real bound;
    logic na;
    logic nb;
    if (sh_type > TY_BOOL) begin
      return (av != ev) ? ST_RAW : ST_MATCH;
    end
    a = element_to_real(sh_type, av);
    b = element_to_real(sh_type, ev);
    na = dbl_is_nan(a);
    nb = dbl_is_nan(b);
    if (na || nb) begin
      return (sh_nan_eq && na && nb) ? ST_MATCH : ST_NAN;
    end
    if (dbl_is_inf(a) || dbl_is_inf(b)) begin
      return (a == b) ? ST_MATCH : ST_INF;
    end
    diff = a - b;
    if (diff < 0.0) diff = -diff;
    bound = (b < 0.0) ? -b : b;
    bound = $bitstoreal(sh_atol) + $bitstoreal(sh_rtol) * bound;
    if (dbl_is_nan(bound)) begin
      return ST_MATCH;
    end
    return (diff > bound) ? ST_TOL : ST_MATCH;
  endfunction

  // result for one accepted beat, advancing the tensor state
  function automatic out_beat_t tensor_verdict(in_beat_t beat);
    out_beat_t r;
    r.status = pair_status(beat.actual_value, beat.expected_value);
    if (r.status != ST_MATCH && !run_failed) begin
      run_failed = 1'b1;
      run_first_bad = run_index;
    end
    r.element_index = run_index;
    r.first_failure_index = run_first_bad;
    r.any_failure = run_failed;
    r.tensor_done = beat.last_element;
    if (beat.last_element) begin
      run_index = '0;
      run_failed = 1'b0;
      run_first_bad = '0;
    end else begin
      run_index = run_index + 32'd1;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %h", out_data);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.status != want.status
            || out_data.element_index != want.element_index
            || out_data.first_failure_index != want.first_failure_index
            || out_data.any_failure != want.any_failure
            || out_data.tensor_done != want.tensor_done) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $write("mismatch: exp st=%0d idx=%0d first=%0d fail=%b done=%b, ",
                   want.status, want.element_index, want.first_failure_index,
                   want.any_failure, want.tensor_done);
            $display("act st=%0d idx=%0d first=%0d fail=%b done=%b",
                     out_data.status, out_data.element_index,
                     out_data.first_failure_index, out_data.any_failure,
                     out_data.tensor_done);
          end
        end
      end
    end
  end

  // receiver stall pattern, character picked by bits 8:6 of the stall cycle counter
  int unsigned stall_cycle;
  always @(negedge clk) begin
    logic [2:0] mode;
    stall_cycle <= stall_cycle + 1;
    mode = stall_cycle[8:6];
    case (mode)
      3'd0, 3'd4: out_ready <= 1'b1;
      3'd1:       out_ready <= ($urandom_range(0, 1) == 1);
      3'd2:       out_ready <= (stall_cycle[1:0] != 2'd0);
      3'd3:       out_ready <= (stall_cycle[4:0] > 5'd20);
      3'd5:       out_ready <= ($urandom_range(0, 7) != 0);
      default:    out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // drive one beat, called and returning at a falling edge
  task automatic send_pair(logic [63:0] av, logic [63:0] ev, logic last);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(4, 12) : $urandom_range(0, 2);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    in_data.actual_value = av;
    in_data.expected_value = ev;
    in_data.last_element = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    verdict_q.push_back(tensor_verdict(in_data));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ELEM_TYPE: sh_type = value[3:0];
      CFG_RTOL:      sh_rtol = value;
      CFG_ATOL:      sh_atol = value;
      default:       sh_nan_eq = value[0];
    endcase
  endtask

  task automatic set_config(logic [3:0] t, logic [63:0] rtol, logic [63:0] atol, logic neq);
    drain_results();
    write_reg(CFG_ELEM_TYPE, {60'd0, t});
    write_reg(CFG_RTOL, rtol);
    write_reg(CFG_ATOL, atol);
    write_reg(CFG_NAN_EQ, {63'd0, neq});
  endtask

  // reset values: f32 with zero tolerance, exact match only
  task automatic test_reset_defaults();
    send_pair(64'h0, 64'h0, 1'b0);
    send_pair(64'hFFFF_FFFF_3F80_0000, 64'h0000_0000_3F80_0000, 1'b0);
    send_pair(64'h3F80_0001, 64'h3F80_0000, 1'b0);
    send_pair(64'h8000_0000, 64'h0000_0000, 1'b1);
  endtask

  task automatic test_special_values();
    set_config(TY_F64, 64'h0, 64'h0, 1'b0);
    send_pair(64'h7FF8_0000_0000_0001, 64'h7FF8_0000_0000_0000, 1'b0);
    send_pair(64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b0);
    send_pair(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b0);
    send_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 1'b1);
    set_config(TY_F16, $realtobits(0.5), $realtobits(0.0), 1'b1);
    send_pair(64'h7E00, 64'hFC01, 1'b0);
    send_pair(64'h0001, 64'h03FF, 1'b0);
    send_pair(64'h7C00, 64'h7BFF, 1'b1);
    set_config(TY_I64, 64'h0, $realtobits(1.0), 1'b0);
    send_pair(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FE00, 1'b1);
    set_config(TY_U64, 64'h0, 64'h0, 1'b0);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FC00, 1'b0);
    set_config(TY_BOOL, 64'h7FF8_0000_0000_0000, 64'h0, 1'b0);
    send_pair(64'hAB01, 64'hCD01, 1'b0);
    send_pair(64'h02, 64'hFF, 1'b1);
    set_config(4'd15, 64'h0, 64'h0, 1'b0);
    send_pair(64'h8000_0000_0000_0000, 64'h0, 1'b0);
    send_pair(64'h1234, 64'h1234, 1'b1);
  endtask

  function automatic logic [63:0] special_bits(logic [3:0] t);
    logic [63:0] pick[8];
    pick[0] = 64'h0;
    case (t)
      TY_F32:  begin pick[1] = 64'h7FC00000; pick[2] = 64'h7F800000; pick[3] = 64'hFF800000; end
      TY_F64:  begin pick[1] = 64'h7FF8_0000_0000_0000; pick[2] = 64'h7FF0_0000_0000_0000;
                     pick[3] = 64'hFFF0_0000_0000_0000; end
      TY_F16:  begin pick[1] = 64'h7E00; pick[2] = 64'h7C00; pick[3] = 64'hFC00; end
      TY_BF16: begin pick[1] = 64'h7FC0; pick[2] = 64'h7F80; pick[3] = 64'hFF80; end
      default: begin pick[1] = 64'h80; pick[2] = 64'h7F; pick[3] = '1; end
    endcase
    pick[4] = 64'h1;
    pick[5] = 64'h8000_0000_0000_0000;
    pick[6] = {$urandom, $urandom};
    pick[7] = '1;
    return pick[$urandom_range(0, 7)];
  endfunction

  // tensors of related pairs with random tails, upper 48 bits of the actual value randomized by coin flip
  task automatic test_random_tensors(int phases, int per_phase);
    logic [63:0] tol_pick[8];
    logic [63:0] ev;
    logic [63:0] av;
    logic [3:0]  t;
    int          k;
    tol_pick[0] = 64'h0;
    tol_pick[1] = $realtobits(1.0e-5);
    tol_pick[2] = $realtobits(1.0e-2);
    tol_pick[3] = $realtobits(0.5);
    tol_pick[4] = $realtobits(3.0);
    tol_pick[5] = 64'h7FF0_0000_0000_0000;
    tol_pick[6] = '1;
    tol_pick[7] = {$urandom, $urandom};
    for (int ph = 0; ph < phases; ph++) begin
      t = 4'(ph % 16);
      set_config(t, tol_pick[$urandom_range(0, 7)], tol_pick[$urandom_range(0, 7)],
                 1'($urandom_range(0, 1)));
      for (int i = 0; i < per_phase; i++) begin
        ev = ($urandom_range(0, 5) == 0) ? special_bits(t) : {$urandom, $urandom};
        k = $urandom_range(0, 7);
        if (k < 4) av = ev;
        else if (k < 6) av = ev ^ 64'($urandom_range(1, 15));
        else if (k == 6) av = special_bits(t);
        else av = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1) av[63:16] = 48'({$urandom, $urandom});
        send_pair(av, ev, $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // sender holds off until everything is back, then resumes the tensor
  task automatic test_drain_pause();
    set_config(TY_I32, $realtobits(0.25), $realtobits(2.0), 1'b0);
    for (int i = 0; i < 30; i++) begin
      send_pair({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      if (i == 14) drain_results();
    end
    send_pair(64'h8000_0000, 64'h7FFF_FFFF, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ELEM_TYPE;
    cfg_data = '0;
    stall_cycle = 0;
    sh_type = TY_F32;
    sh_rtol = '0;
    sh_atol = '0;
    sh_nan_eq = 1'b0;
    run_index = '0;
    run_failed = 1'b0;
    run_first_bad = '0;
    mismatch_count = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_special_values();
    test_drain_pause();
    test_random_tensors(20, 68);
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_tolerance_compare_stream passed");
    end else begin
      $display("tb_tolerance_compare_stream failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_tolerance_compare_stream failed");
    $finish;
  end

endmodule
